/* sv/ssv_pkg.sv */
`default_nettype none
package ssv_pkg;

   // field widths
   localparam int POS_W   = 24;
   localparam int VEL_W   = 16;
   localparam int MAG_W   = 16;
   localparam int STEER_W = 18;

   // first normalisation: |d| in Q.7, desired velocity quotient
   localparam int RAD1_W  = 64;
   localparam int NUM1_W  = 47;
   localparam int LEN_W   = RAD1_W / 2;
   localparam int QUO_W   = 17;

   // second normalisation: |s| in Q.8, clamped steering quotient
   localparam int RAD2_W  = 52;
   localparam int NUM2_W  = 41;
   localparam int MAGS_W  = RAD2_W / 2;

   // register indexes
   localparam logic [7:0] CSR_TARGET_X = 8'd0;
   localparam logic [7:0] CSR_TARGET_Y = 8'd1;

   // pipeline control handed to each arithmetic unit
   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

   // carried alongside the first square root
   typedef struct packed {
      logic                    sgn_x;
      logic                    sgn_y;
      logic [NUM1_W-1:0]       num_x;
      logic [NUM1_W-1:0]       num_y;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic [MAG_W-1:0]        accel;
      logic                    on_target;
   } sq1_sb_type;

   // carried alongside the first divider
   typedef struct packed {
      logic                    sgn_x;
      logic                    sgn_y;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic [MAG_W-1:0]        accel;
      logic                    on_target;
   } dv1_sb_type;

   // carried alongside the second square root
   typedef struct packed {
      logic [NUM2_W-1:0]         num_x;
      logic [NUM2_W-1:0]         num_y;
      logic signed [STEER_W-1:0] s_x;
      logic signed [STEER_W-1:0] s_y;
      logic                      clamp;
      logic                      on_target;
   } sq2_sb_type;

   // carried alongside the second divider
   typedef struct packed {
      logic signed [STEER_W-1:0] s_x;
      logic signed [STEER_W-1:0] s_y;
      logic                      clamp;
      logic                      on_target;
   } dv2_sb_type;

endpackage
`default_nettype wire

/* sv/ssv_isqrt.sv */
`default_nettype none
// Pipelined floor square root, one result bit per stage
module ssv_isqrt import ssv_pkg::*; #(
   parameter int IN_W = RAD1_W,
   parameter int SB_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pipe_ctl_type        ctl,
   input  wire logic [IN_W-1:0]     rad,
   input  wire logic [SB_W-1:0]     sb_in,
   output logic                     out_valid,
   output logic [IN_W/2-1:0]        root,
   output logic [SB_W-1:0]          sb_out
);

   localparam int R = IN_W / 2;

   logic [R-1:0]    valid_ff;
   logic [IN_W-1:0] rad_ff  [R];
   logic [R+1:0]    rem_ff  [R];
   logic [R-1:0]    root_ff [R];
   logic [SB_W-1:0] sb_ff   [R];

   for (genvar k = 0; k < R; k++) begin : g_stage
      logic            v_prev;
      logic [IN_W-1:0] rad_prev;
      logic [R+1:0]    rem_prev;
      logic [R-1:0]    root_prev;
      logic [SB_W-1:0] sb_prev;
      logic [R+1:0]    rem_sh;
      logic [R+1:0]    trial;
      logic [R+1:0]    rem_in;
      logic [R-1:0]    root_in;

      if (k == 0) begin : g_first
         assign v_prev    = ctl.valid;
         assign rad_prev  = rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign sb_prev   = sb_in;
      end else begin : g_next
         assign v_prev    = valid_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign sb_prev   = sb_ff[k-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
         rem_sh = {rem_prev[R-1:0], rad_prev[IN_W-1 -: 2]};
         trial  = {root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[R-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[R-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ctl.en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            rad_ff[k]  <= rad_prev << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            sb_ff[k]   <= sb_prev;
         end
      end
   end

   assign out_valid = valid_ff[R-1];
   assign root      = root_ff[R-1];
   assign sb_out    = sb_ff[R-1];

endmodule
`default_nettype wire

/* sv/ssv_div.sv */
`default_nettype none
// Pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage
module ssv_div import ssv_pkg::*; #(
   parameter int NUM_W = NUM1_W,
   parameter int DEN_W = LEN_W,
   parameter int QUO_W = 17,
   parameter int SB_W  = 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pipe_ctl_type       ctl,
   input  wire logic [NUM_W-1:0]   num_a,
   input  wire logic [NUM_W-1:0]   num_b,
   input  wire logic [DEN_W-1:0]   den,
   input  wire logic [SB_W-1:0]    sb_in,
   output logic                    out_valid,
   output logic [QUO_W-1:0]        quo_a,
   output logic [QUO_W-1:0]        quo_b,
   output logic [SB_W-1:0]         sb_out
);

   localparam int W = DEN_W + QUO_W;

   logic [QUO_W-1:0] valid_ff;
   logic [W-1:0]     rem_a_ff [QUO_W];
   logic [W-1:0]     rem_b_ff [QUO_W];
   logic [QUO_W-1:0] q_a_ff   [QUO_W];
   logic [QUO_W-1:0] q_b_ff   [QUO_W];
   logic [DEN_W-1:0] den_ff   [QUO_W];
   logic [SB_W-1:0]  sb_ff    [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int B = QUO_W - 1 - k;
      logic             v_prev;
      logic [W-1:0]     rem_a_prev;
      logic [W-1:0]     rem_b_prev;
      logic [QUO_W-1:0] q_a_prev;
      logic [QUO_W-1:0] q_b_prev;
      logic [DEN_W-1:0] den_prev;
      logic [SB_W-1:0]  sb_prev;
      logic [W-1:0]     sub;
      logic [W-1:0]     rem_a_in;
      logic [W-1:0]     rem_b_in;
      logic [QUO_W-1:0] q_a_in;
      logic [QUO_W-1:0] q_b_in;

      if (k == 0) begin : g_first
         assign v_prev     = ctl.valid;
         assign rem_a_prev = W'(num_a);
         assign rem_b_prev = W'(num_b);
         assign q_a_prev   = '0;
         assign q_b_prev   = '0;
         assign den_prev   = den;
         assign sb_prev    = sb_in;
      end else begin : g_next
         assign v_prev     = valid_ff[k-1];
         assign rem_a_prev = rem_a_ff[k-1];
         assign rem_b_prev = rem_b_ff[k-1];
         assign q_a_prev   = q_a_ff[k-1];
         assign q_b_prev   = q_b_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign sb_prev    = sb_ff[k-1];
      end

      // compare each lane with the divisor at this bit weight
      always_comb begin
         sub = W'(den_prev) << B;
         if (rem_a_prev >= sub) begin
            rem_a_in = rem_a_prev - sub;
            q_a_in   = {q_a_prev[QUO_W-2:0], 1'b1};
         end else begin
            rem_a_in = rem_a_prev;
            q_a_in   = {q_a_prev[QUO_W-2:0], 1'b0};
         end
         if (rem_b_prev >= sub) begin
            rem_b_in = rem_b_prev - sub;
            q_b_in   = {q_b_prev[QUO_W-2:0], 1'b1};
         end else begin
            rem_b_in = rem_b_prev;
            q_b_in   = {q_b_prev[QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ctl.en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            rem_a_ff[k] <= rem_a_in;
            rem_b_ff[k] <= rem_b_in;
            q_a_ff[k]   <= q_a_in;
            q_b_ff[k]   <= q_b_in;
            den_ff[k]   <= den_prev;
            sb_ff[k]    <= sb_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign quo_a     = q_a_ff[QUO_W-1];
   assign quo_b     = q_b_ff[QUO_W-1];
   assign sb_out    = sb_ff[QUO_W-1];

endmodule
`default_nettype wire

/* sv/seek_steering_vector_unit.sv */
`default_nettype none
// Seek steering: desired velocity towards the target minus velocity, length limited.
// Path from an accepted request to rsp_tvalid: 4 front stages, 32-stage and 26-stage
// square roots, two 17-stage dividers, 4 middle stages, output register.
// Throughput: one transaction per cycle; the whole pipeline holds only while a
// result waits in the output register and another has reached the last stage.
// Reset (synchronous): clears all valid bits and both target registers to zero.
module seek_steering_vector_unit import ssv_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   // request: pos_x[23:0], pos_y[47:24], vel_x[63:48], vel_y[79:64],
   //          top_speed[95:80], top_accel[111:96]
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [111:0]  req_tdata,
   // response: steer_x[17:0], steer_y[35:18], zero padding above
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [39:0]        rsp_tdata,
   // register writes
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [7:0]    csr_index,
   input  wire logic [23:0]   csr_data
);

   // ---------------- registers ----------------
   logic signed [POS_W-1:0] target_x_ff, target_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff <= '0;
         target_y_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TARGET_X: target_x_ff <= csr_data;
            CSR_TARGET_Y: target_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline enable ----------------
   logic         en;
   logic         last_valid;
   pipe_ctl_type ctl_sq1, ctl_dv1, ctl_sq2, ctl_dv2;

   // advance unless a waiting result would be overwritten
   assign en         = !rsp_tvalid || rsp_tready || !last_valid;
   assign req_tready = en;

   // ---------------- stage 0: offsets ----------------
   logic signed [POS_W-1:0] pos_x, pos_y;
   logic signed [VEL_W-1:0] vel_x, vel_y;
   logic [MAG_W-1:0]        top_speed, top_accel;

   assign pos_x     = req_tdata[23:0];
   assign pos_y     = req_tdata[47:24];
   assign vel_x     = req_tdata[63:48];
   assign vel_y     = req_tdata[79:64];
   assign top_speed = req_tdata[95:80];
   assign top_accel = req_tdata[111:96];

   logic                    v0_ff;
   logic signed [POS_W:0]   dx0_ff, dy0_ff, dx0_in, dy0_in;
   logic signed [VEL_W-1:0] vx0_ff, vy0_ff;
   logic [MAG_W-1:0]        spd0_ff, acc0_ff;

   assign dx0_in = (POS_W+1)'(target_x_ff) - (POS_W+1)'(pos_x);
   assign dy0_in = (POS_W+1)'(target_y_ff) - (POS_W+1)'(pos_y);

   // ---------------- stage 1: magnitudes ----------------
   logic                    v1_ff;
   logic [POS_W-1:0]        adx1_ff, ady1_ff, adx1_in, ady1_in;
   logic                    sgnx1_ff, sgny1_ff, zero1_ff;
   logic signed [VEL_W-1:0] vx1_ff, vy1_ff;
   logic [MAG_W-1:0]        spd1_ff, acc1_ff;
   logic signed [POS_W:0]   ndx0, ndy0;

   always_comb begin
      ndx0    = -dx0_ff;
      ndy0    = -dy0_ff;
      adx1_in = dx0_ff[POS_W] ? POS_W'(ndx0) : POS_W'(dx0_ff);
      ady1_in = dy0_ff[POS_W] ? POS_W'(ndy0) : POS_W'(dy0_ff);
   end

   // ---------------- stage 2: squares and numerators ----------------
   logic                         v2_ff;
   logic [2*POS_W-1:0]           sqx2_ff, sqy2_ff;
   logic [NUM1_W-1:0]            numx2_ff, numy2_ff;
   logic [POS_W+MAG_W-1:0]       prx1, pry1;
   logic                         sgnx2_ff, sgny2_ff, zero2_ff;
   logic signed [VEL_W-1:0]      vx2_ff, vy2_ff;
   logic [MAG_W-1:0]             acc2_ff;

   assign prx1 = adx1_ff * spd1_ff;
   assign pry1 = ady1_ff * spd1_ff;

   // ---------------- stage 3: radicand ----------------
   logic              v3_ff;
   logic [RAD1_W-1:0] rad3_ff, rad3_in;
   sq1_sb_type        sb3_ff, sb3_in;
   logic [2*POS_W:0]  sum2;

   always_comb begin
      sum2             = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
      rad3_in          = RAD1_W'({sum2, 14'b0});
      sb3_in.sgn_x     = sgnx2_ff;
      sb3_in.sgn_y     = sgny2_ff;
      sb3_in.num_x     = numx2_ff;
      sb3_in.num_y     = numy2_ff;
      sb3_in.vel_x     = vx2_ff;
      sb3_in.vel_y     = vy2_ff;
      sb3_in.accel     = acc2_ff;
      sb3_in.on_target = zero2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx0_ff   <= dx0_in;
         dy0_ff   <= dy0_in;
         vx0_ff   <= vel_x;
         vy0_ff   <= vel_y;
         spd0_ff  <= top_speed;
         acc0_ff  <= top_accel;

         adx1_ff  <= adx1_in;
         ady1_ff  <= ady1_in;
         sgnx1_ff <= dx0_ff[POS_W];
         sgny1_ff <= dy0_ff[POS_W];
         zero1_ff <= (dx0_ff == '0) && (dy0_ff == '0);
         vx1_ff   <= vx0_ff;
         vy1_ff   <= vy0_ff;
         spd1_ff  <= spd0_ff;
         acc1_ff  <= acc0_ff;

         sqx2_ff  <= adx1_ff * adx1_ff;
         sqy2_ff  <= ady1_ff * ady1_ff;
         numx2_ff <= {prx1, 7'b0};
         numy2_ff <= {pry1, 7'b0};
         sgnx2_ff <= sgnx1_ff;
         sgny2_ff <= sgny1_ff;
         zero2_ff <= zero1_ff;
         vx2_ff   <= vx1_ff;
         vy2_ff   <= vy1_ff;
         acc2_ff  <= acc1_ff;

         rad3_ff  <= rad3_in;
         sb3_ff   <= sb3_in;
      end
   end

   // ---------------- |d| and desired velocity ----------------
   logic             sq1_valid;
   logic [LEN_W-1:0] len;
   logic [$bits(sq1_sb_type)-1:0] sq1_sb_raw;
   sq1_sb_type       sq1_sb;
   dv1_sb_type       dv1_sb_in;
   logic [LEN_W-1:0] len_den;

   assign ctl_sq1.en    = en;
   assign ctl_sq1.valid = v3_ff;

   ssv_isqrt #(
      .IN_W (RAD1_W),
      .SB_W ($bits(sq1_sb_type))
   ) u_sqrt_len (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_sq1),
      .rad       (rad3_ff),
      .sb_in     (sb3_ff),
      .out_valid (sq1_valid),
      .root      (len),
      .sb_out    (sq1_sb_raw)
   );

   always_comb begin
      sq1_sb              = sq1_sb_raw;
      len_den             = (len == '0) ? LEN_W'(1) : len;
      dv1_sb_in.sgn_x     = sq1_sb.sgn_x;
      dv1_sb_in.sgn_y     = sq1_sb.sgn_y;
      dv1_sb_in.vel_x     = sq1_sb.vel_x;
      dv1_sb_in.vel_y     = sq1_sb.vel_y;
      dv1_sb_in.accel     = sq1_sb.accel;
      dv1_sb_in.on_target = sq1_sb.on_target;
   end

   assign ctl_dv1.en    = en;
   assign ctl_dv1.valid = sq1_valid;

   logic             dv1_valid;
   logic [QUO_W-1:0] desx_q, desy_q;
   logic [$bits(dv1_sb_type)-1:0] dv1_sb_raw;
   dv1_sb_type       dv1_sb;

   ssv_div #(
      .NUM_W (NUM1_W),
      .DEN_W (LEN_W),
      .QUO_W (QUO_W),
      .SB_W  ($bits(dv1_sb_type))
   ) u_div_desired (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_dv1),
      .num_a     (sq1_sb.num_x),
      .num_b     (sq1_sb.num_y),
      .den       (len_den),
      .sb_in     (dv1_sb_in),
      .out_valid (dv1_valid),
      .quo_a     (desx_q),
      .quo_b     (desy_q),
      .sb_out    (dv1_sb_raw)
   );

   assign dv1_sb = dv1_sb_raw;

   // ---------------- stage 4: steering difference ----------------
   logic                      v4_ff;
   logic signed [STEER_W-1:0] sx4_ff, sy4_ff, sx4_in, sy4_in;
   logic signed [STEER_W-1:0] desx, desy;
   logic [MAG_W-1:0]          acc4_ff;
   logic                      zero4_ff;

   always_comb begin
      desx   = dv1_sb.sgn_x ? -STEER_W'(desx_q) : STEER_W'(desx_q);
      desy   = dv1_sb.sgn_y ? -STEER_W'(desy_q) : STEER_W'(desy_q);
      sx4_in = desx - STEER_W'(dv1_sb.vel_x);
      sy4_in = desy - STEER_W'(dv1_sb.vel_y);
   end

   // ---------------- stage 5: magnitudes ----------------
   logic                      v5_ff;
   logic [QUO_W-1:0]          asx5_ff, asy5_ff, asx5_in, asy5_in;
   logic signed [STEER_W-1:0] sx5_ff, sy5_ff, nsx4, nsy4;
   logic [MAG_W-1:0]          acc5_ff;
   logic                      zero5_ff;

   always_comb begin
      nsx4    = -sx4_ff;
      nsy4    = -sy4_ff;
      asx5_in = sx4_ff[STEER_W-1] ? QUO_W'(nsx4) : QUO_W'(sx4_ff);
      asy5_in = sy4_ff[STEER_W-1] ? QUO_W'(nsy4) : QUO_W'(sy4_ff);
   end

   // ---------------- stage 6: squares and numerators ----------------
   logic                      v6_ff;
   logic [2*QUO_W-1:0]        sqx6_ff, sqy6_ff;
   logic [2*MAG_W-1:0]        acsq6_ff;
   logic [NUM2_W-1:0]         numx6_ff, numy6_ff;
   logic [QUO_W+MAG_W-1:0]    prx5, pry5;
   logic signed [STEER_W-1:0] sx6_ff, sy6_ff;
   logic                      zero6_ff;

   assign prx5 = asx5_ff * acc5_ff;
   assign pry5 = asy5_ff * acc5_ff;

   // ---------------- stage 7: |s|^2, clamp decision ----------------
   logic              v7_ff;
   logic [RAD2_W-1:0] rad7_ff, rad7_in;
   sq2_sb_type        sb7_ff, sb7_in;
   logic [2*QUO_W:0]  qsum6;

   always_comb begin
      qsum6            = {1'b0, sqx6_ff} + {1'b0, sqy6_ff};
      rad7_in          = RAD2_W'({qsum6, 16'b0});
      sb7_in.num_x     = numx6_ff;
      sb7_in.num_y     = numy6_ff;
      sb7_in.s_x       = sx6_ff;
      sb7_in.s_y       = sy6_ff;
      sb7_in.clamp     = qsum6 > (2*QUO_W+1)'(acsq6_ff);
      sb7_in.on_target = zero6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= dv1_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx4_ff   <= sx4_in;
         sy4_ff   <= sy4_in;
         acc4_ff  <= dv1_sb.accel;
         zero4_ff <= dv1_sb.on_target;

         asx5_ff  <= asx5_in;
         asy5_ff  <= asy5_in;
         sx5_ff   <= sx4_ff;
         sy5_ff   <= sy4_ff;
         acc5_ff  <= acc4_ff;
         zero5_ff <= zero4_ff;

         sqx6_ff  <= asx5_ff * asx5_ff;
         sqy6_ff  <= asy5_ff * asy5_ff;
         acsq6_ff <= acc5_ff * acc5_ff;
         numx6_ff <= {prx5, 8'b0};
         numy6_ff <= {pry5, 8'b0};
         sx6_ff   <= sx5_ff;
         sy6_ff   <= sy5_ff;
         zero6_ff <= zero5_ff;

         rad7_ff  <= rad7_in;
         sb7_ff   <= sb7_in;
      end
   end

   // ---------------- |s| and rescaled steering ----------------
   logic              sq2_valid;
   logic [MAGS_W-1:0] mag, mag_den;
   logic [$bits(sq2_sb_type)-1:0] sq2_sb_raw;
   sq2_sb_type        sq2_sb;
   dv2_sb_type        dv2_sb_in;

   assign ctl_sq2.en    = en;
   assign ctl_sq2.valid = v7_ff;

   ssv_isqrt #(
      .IN_W (RAD2_W),
      .SB_W ($bits(sq2_sb_type))
   ) u_sqrt_mag (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_sq2),
      .rad       (rad7_ff),
      .sb_in     (sb7_ff),
      .out_valid (sq2_valid),
      .root      (mag),
      .sb_out    (sq2_sb_raw)
   );

   always_comb begin
      sq2_sb              = sq2_sb_raw;
      mag_den             = (mag == '0) ? MAGS_W'(1) : mag;
      dv2_sb_in.s_x       = sq2_sb.s_x;
      dv2_sb_in.s_y       = sq2_sb.s_y;
      dv2_sb_in.clamp     = sq2_sb.clamp;
      dv2_sb_in.on_target = sq2_sb.on_target;
   end

   assign ctl_dv2.en    = en;
   assign ctl_dv2.valid = sq2_valid;

   logic             dv2_valid;
   logic [QUO_W-1:0] outx_q, outy_q;
   logic [$bits(dv2_sb_type)-1:0] dv2_sb_raw;
   dv2_sb_type       dv2_sb;

   ssv_div #(
      .NUM_W (NUM2_W),
      .DEN_W (MAGS_W),
      .QUO_W (QUO_W),
      .SB_W  ($bits(dv2_sb_type))
   ) u_div_clamp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_dv2),
      .num_a     (sq2_sb.num_x),
      .num_b     (sq2_sb.num_y),
      .den       (mag_den),
      .sb_in     (dv2_sb_in),
      .out_valid (dv2_valid),
      .quo_a     (outx_q),
      .quo_b     (outy_q),
      .sb_out    (dv2_sb_raw)
   );

   assign dv2_sb     = dv2_sb_raw;
   assign last_valid = dv2_valid;

   // ---------------- output register ----------------
   // clamped quotients stay below 2^17 and unclamped steering fits Q10.8,
   // so the result never needs saturating
   logic                      rsp_valid_ff;
   logic signed [STEER_W-1:0] steer_x_ff, steer_y_ff, steer_x_in, steer_y_in;

   always_comb begin
      if (dv2_sb.on_target) begin
         steer_x_in = '0;
         steer_y_in = '0;
      end else if (dv2_sb.clamp) begin
         steer_x_in = dv2_sb.s_x[STEER_W-1] ? -STEER_W'(outx_q) : STEER_W'(outx_q);
         steer_y_in = dv2_sb.s_y[STEER_W-1] ? -STEER_W'(outy_q) : STEER_W'(outy_q);
      end else begin
         steer_x_in = dv2_sb.s_x;
         steer_y_in = dv2_sb.s_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && last_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && last_valid) begin
         steer_x_ff <= steer_x_in;
         steer_y_ff <= steer_y_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, steer_y_ff, steer_x_ff};

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import ssv_pkg::*;

   localparam int LATENCY   = 101;
   localparam int N_RANDOM  = 1600;
   localparam int WATCHDOG  = 20000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [39:0]   rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [7:0]    csr_index = '0;
   logic [23:0]   csr_data = '0;

   seek_steering_vector_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // agent transaction
   typedef struct packed {
      logic [15:0] accel;
      logic [15:0] speed;
      logic signed [15:0] vy;
      logic signed [15:0] vx;
      logic signed [23:0] py;
      logic signed [23:0] px;
   } agent_type;

   typedef struct {
      agent_type a;
      bit     known;
      logic [35:0] steer;
   } stim_row_type;

   logic signed [23:0] aim_x = '0, aim_y = '0;
   logic [35:0] steer_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 0;

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint signed scaled(longint signed v, longint unsigned k,
                                            longint unsigned den);
      longint unsigned m, q;
      m = (v < 0) ? -v : v;
      q = (m * k) / den;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [17:0] sat18(longint signed v);
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return v[17:0];
   endfunction

   // steering vector predicted for one agent, {steer_y, steer_x}
   function automatic logic [35:0] seek_steer(agent_type a);
      longint signed dx, dy, sx, sy;
      longint unsigned len, q, m, ax, ay;
      dx = longint'(aim_x) - longint'(a.px);
      dy = longint'(aim_y) - longint'(a.py);
      if (dx == 0 && dy == 0) return '0;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      len = root64((ax * ax + ay * ay) << 14);
      if (len == 0) len = 1;
      sx = scaled(dx, 64'(a.speed) * 128, len) - longint'(a.vx);
      sy = scaled(dy, 64'(a.speed) * 128, len) - longint'(a.vy);
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      q = ax * ax + ay * ay;
      if (q == 0) return '0;
      if (q > 64'(a.accel) * 64'(a.accel)) begin
         m = root64(q << 16);
         if (m == 0) m = 1;
         sx = scaled(sx, 64'(a.accel) * 256, m);
         sy = scaled(sy, 64'(a.accel) * 256, m);
      end
      return {sat18(sy), sat18(sx)};
   endfunction

   task automatic report_mismatch(string what, logic [35:0] got, logic [35:0] want);
      $display("mismatch %s: got x=%0d y=%0d, expected x=%0d y=%0d", what,
               $signed(got[17:0]), $signed(got[35:18]),
               $signed(want[17:0]), $signed(want[35:18]));
      errors++;
   endtask

   // response checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            if (steer_queue.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tdata[35:0], '0);
            end else begin
               logic [35:0] want;
               want = steer_queue.pop_front();
               if (rsp_tdata[17:0] !== want[17:0])
                  report_mismatch("steer_x", rsp_tdata[35:0], want);
               else if (rsp_tdata[35:18] !== want[35:18])
                  report_mismatch("steer_y", rsp_tdata[35:0], want);
            end
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("FAIL");
            $finish;
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      int n;
      @(negedge clock);
      while (1) begin
         rsp_tready <= 1'b1;
         n = $urandom_range(1, 30);
         repeat (n) @(negedge clock);
         if (!quiet && $urandom_range(0, 1)) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(negedge clock);
         end
      end
   end

   // valid stays high on return so back to back writes need no second update
   task automatic write_target(logic [7:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_TARGET_X) aim_x = val;
      else if (idx == CSR_TARGET_Y) aim_y = val;
      @(negedge clock);
   endtask

   // valid is lowered only for an idle gap or by drain
   task automatic send_agent(agent_type a, bit known, logic [35:0] want);
      int n;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         n = $urandom_range(1, 14);
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= a;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      steer_queue.push_back(known ? want : seek_steer(a));
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (steer_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   function automatic agent_type random_agent(int mode);
      agent_type a;
      a.px = 24'($urandom); a.py = 24'($urandom);
      a.vx = 16'($urandom); a.vy = 16'($urandom);
      a.speed = 16'($urandom); a.accel = 16'($urandom);
      case (mode)
         0: begin // near the target, small numbers
            a.px = aim_x + $signed(24'($urandom_range(0, 2000)) - 24'd1000);
            a.py = aim_y + $signed(24'($urandom_range(0, 2000)) - 24'd1000);
            a.vx = $signed(16'($urandom_range(0, 2048)) - 16'd1024);
            a.vy = $signed(16'($urandom_range(0, 2048)) - 16'd1024);
            a.speed = 16'($urandom_range(0, 4096));
            a.accel = 16'($urandom_range(0, 4096));
         end
         1: begin a.px = aim_x; a.py = aim_y; end
         2: a.accel = 16'hFFFF;
         3: a.speed = 16'd0;
         default: ;
      endcase
      return a;
   endfunction

   initial begin
      stim_row_type rows[$];
      agent_type a;
      logic [23:0] targets[4];
      targets = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h012345};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows with the target at its reset value
      a = '0;
      rows.push_back('{a, 1, 36'd0});            // on target
      a.vx = 16'sd100; a.accel = 16'hFFFF;
      rows.push_back('{a, 1, 36'd0});            // on target, moving
      a = '0; a.px = -24'sd256;
      rows.push_back('{a, 1, 36'd0});            // zero speed, zero velocity
      a.vx = 16'sd300; a.accel = 16'hFFFF;
      rows.push_back('{a, 1, {18'd0, 18'h3FED4}}); // steering is -vel
      a.accel = 16'd0;
      rows.push_back('{a, 1, 36'd0});            // zero accel
      a = '0; a.px = 24'h7FFFFF; a.py = 24'h7FFFFF; a.speed = 16'hFFFF;
      a.accel = 16'hFFFF; a.vx = 16'h7FFF; a.vy = 16'h8000;
      rows.push_back('{a, 0, 36'd0});
      a.px = 24'h800000; a.py = 24'h800000; a.vx = 16'h8000; a.vy = 16'h7FFF;
      rows.push_back('{a, 0, 36'd0});
      a = '0; a.px = 24'sd1; a.speed = 16'hFFFF; a.accel = 16'hFFFF;
      rows.push_back('{a, 0, 36'd0});
      a.speed = 16'd256; a.accel = 16'd10;
      rows.push_back('{a, 0, 36'd0});
      foreach (rows[i]) send_agent(rows[i].a, rows[i].known, rows[i].steer);
      drain();

      // out-of-range index is ignored
      write_target(8'd2, 24'h123456);
      write_target(8'hFF, 24'hABCDEF);

      for (int ph = 0; ph < 8; ph++) begin
         write_target(CSR_TARGET_X, (ph < 4) ? targets[ph] : 24'($urandom));
         write_target(CSR_TARGET_Y, (ph < 4) ? targets[3 - ph] : 24'($urandom));
         csr_valid <= 1'b0;
         if (ph == 7) quiet = 1;
         for (int k = 0; k < N_RANDOM / 8; k++) begin
            int mode;
            mode = $urandom_range(0, 9);
            a = random_agent(mode);
            // back to back bursts
            send_agent(a, 0, '0);
         end
         drain();
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
